// ===== sv/double_ended_message_queue_macros.svh =====
// assertion macros shared by the message queue rtl
// no dependencies; each use sits on a line of its own
`ifndef DOUBLE_ENDED_MESSAGE_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_MESSAGE_QUEUE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DEMQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("demq assertion failed");

// same-cycle implication checked at every clock edge out of reset
`define DEMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("demq implication failed");

// next-cycle implication checked at every clock edge out of reset
`define DEMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("demq next-cycle implication failed");

`endif

// ===== sv/demq_pkg.sv =====
// shared types and constants for the double-ended message queue
// no dependencies
`default_nettype none

package demq_pkg;

    // fixed port field widths
    localparam int CNT_W       = 5;
    localparam int PORT_DATA_W = 32;
    localparam int FUNC_W      = 3;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_SEND_BACK  = 3'd0,
        FN_SEND_FRONT = 3'd1,
        FN_OVERWRITE  = 3'd2,
        FN_RECEIVE    = 3'd3,
        FN_PEEK       = 3'd4
    } t_func;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic exec;   // execute the accepted item
        logic load;   // capture memory read data into the result
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== sv/demq_ctrl.sv =====
// controller state machine: input handshake, sequencing, output handshake
// depends on demq_pkg
`default_nettype none

module demq_ctrl
    import demq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // handshake and command outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.exec = i_in_valid;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/demq_dp.sv =====
// datapath: slot memory, ring indices, item count, capacity and result registers
// depends on demq_pkg and the assertion macro header
`default_nettype none
`include "double_ended_message_queue_macros.svh"

module demq_dp
    import demq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    input  wire logic [FUNC_W-1:0]      i_func,
    input  wire logic [PORT_DATA_W-1:0] i_write_data,
    input  wire logic                   i_cfg_we,
    input  wire logic [CNT_W-1:0]       i_cfg_wdata,
    output logic                        o_ok,
    output logic [PORT_DATA_W-1:0]      o_read_data,
    output logic [CNT_W-1:0]            o_msg_count,
    output logic [CNT_W-1:0]            o_free_space
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = ($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W;
    localparam int EXT_W = (DATA_WIDTH > PORT_DATA_W) ? DATA_WIDTH : PORT_DATA_W;
    localparam logic [CAP_W-1:0] CAP_RST = CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_ONE = CAP_W'(1);

    // slot store and its registered read port
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_mem_q;

    // queue state
    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] r_count;
    logic [IDX_W-1:0] r_back;
    logic [IDX_W-1:0] r_front;
    logic [CAP_W-1:0] n_cap;
    logic [CAP_W-1:0] n_count;
    logic [IDX_W-1:0] n_back;
    logic [IDX_W-1:0] n_front;

    // result registers
    logic                   r_ok;
    logic                   r_rd_sel;
    logic [PORT_DATA_W-1:0] r_rd;
    logic [CNT_W-1:0]       r_msg_count;
    logic [CNT_W-1:0]       r_free;

    // operation decode
    t_func                 func;
    logic                  full;
    logic                  empty;
    logic [CAP_W-1:0]      cap_m1;
    logic                  front_last;
    logic                  back_last;
    logic [IDX_W-1:0]      front_next;
    logic [IDX_W-1:0]      front_prev;
    logic [IDX_W-1:0]      back_next;
    logic [IDX_W-1:0]      back_prev;
    logic                  op_ok;
    logic                  op_read;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [EXT_W-1:0]      wd_ext;
    logic [DATA_WIDTH-1:0] wd;
    logic [EXT_W-1:0]      rd_ext;
    logic [CAP_W-1:0]      cfg_v;
    logic [CAP_W-1:0]      cfg_cap;
    logic [CAP_W-1:0]      free_cnt;

    assign func   = t_func'(i_func);
    assign full   = (r_count >= r_cap);
    assign empty  = (r_count == '0);
    assign cap_m1 = r_cap - CAP_ONE;

    // ring index neighbors within the active capacity
    assign front_last = (CAP_W'(r_front) == cap_m1);
    assign back_last  = (CAP_W'(r_back) == cap_m1);
    assign front_next = front_last ? '0 : r_front + IDX_W'(1);
    assign back_next  = back_last ? '0 : r_back + IDX_W'(1);
    assign front_prev = (r_front == '0) ? IDX_W'(cap_m1) : r_front - IDX_W'(1);
    assign back_prev  = (r_back == '0) ? IDX_W'(cap_m1) : r_back - IDX_W'(1);

    // item data sized to the store
    assign wd_ext = EXT_W'(i_write_data);
    assign wd     = wd_ext[DATA_WIDTH-1:0];

    // capacity write clamped to one through depth
    assign cfg_v = CAP_W'(i_cfg_wdata);
    always_comb begin
        priority if (cfg_v == '0) begin
            cfg_cap = CAP_ONE;
        end else if (cfg_v > CAP_RST) begin
            cfg_cap = CAP_RST;
        end else begin
            cfg_cap = cfg_v;
        end
    end

    // next queue state and memory access for the executed item
    always_comb begin
        n_cap     = r_cap;
        n_count   = r_count;
        n_back    = r_back;
        n_front   = r_front;
        op_ok     = 1'b0;
        op_read   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_front;
        mem_raddr = front_next;
        unique case (func)
            FN_SEND_BACK: begin
                if (!full) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_back;
                    n_back    = back_next;
                    n_count   = r_count + CAP_ONE;
                    op_ok     = 1'b1;
                end
            end
            FN_SEND_FRONT: begin
                if (!full) begin
                    mem_we  = 1'b1;
                    n_front = front_prev;
                    n_count = r_count + CAP_ONE;
                    op_ok   = 1'b1;
                end
            end
            FN_OVERWRITE: begin
                mem_we  = 1'b1;
                n_front = front_prev;
                op_ok   = 1'b1;
                if (full) begin
                    n_back = back_prev;
                end else begin
                    n_count = r_count + CAP_ONE;
                end
            end
            FN_RECEIVE: begin
                if (!empty) begin
                    n_front = front_next;
                    n_count = r_count - CAP_ONE;
                    op_ok   = 1'b1;
                    op_read = 1'b1;
                end
            end
            FN_PEEK: begin
                if (!empty) begin
                    op_ok   = 1'b1;
                    op_read = 1'b1;
                end
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign free_cnt = r_cap - n_count;

    // queue state registers; a capacity write empties the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RST;
            r_count <= '0;
            r_back  <= '0;
            r_front <= IDX_W'(DEPTH - 1);
        end else if (i_cfg_we) begin
            r_cap   <= cfg_cap;
            r_count <= '0;
            r_back  <= '0;
            r_front <= IDX_W'(cfg_cap - CAP_ONE);
        end else if (i_cmd.exec) begin
            r_cap   <= n_cap;
            r_count <= n_count;
            r_back  <= n_back;
            r_front <= n_front;
        end
    end

    // slot memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we && !i_cfg_we) begin
            mem[mem_waddr] <= wd;
        end
        if (i_cmd.exec) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    assign rd_ext = EXT_W'(r_mem_q);

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok        <= op_ok;
            r_rd_sel    <= op_read;
            r_msg_count <= CNT_W'(n_count);
            r_free      <= CNT_W'(free_cnt);
        end
        if (i_cmd.load) begin
            r_rd <= r_rd_sel ? rd_ext[PORT_DATA_W-1:0] : '0;
        end
    end

    assign o_ok         = r_ok;
    assign o_read_data  = r_rd;
    assign o_msg_count  = r_msg_count;
    assign o_free_space = r_free;

    // checks
    `DEMQ_ASSERT(a_count_le_cap, i_clk, i_rst_n, r_count <= r_cap)
    `DEMQ_ASSERT(a_cap_range, i_clk, i_rst_n, (r_cap >= CAP_ONE) && (r_cap <= CAP_RST))
    `DEMQ_ASSERT_NEXT(a_full_overwrite_keeps_count, i_clk, i_rst_n, i_cmd.exec && !i_cfg_we && full && (func == FN_OVERWRITE), $stable(r_count))
    `DEMQ_ASSERT_NEXT(a_send_back_grows, i_clk, i_rst_n, i_cmd.exec && !i_cfg_we && !full && (func == FN_SEND_BACK), r_count == $past(r_count) + CAP_ONE)

endmodule

`default_nettype wire

// ===== sv/double_ended_message_queue.sv =====
// sequencing: the controller runs execute, memory read capture and output hold, one item
//   at a time; a new item is accepted only once the result has been taken with no output stall
// reset: synchronous, active low; empties the queue and sets capacity to DEPTH,
//   the slot store is not cleared and needs no clearing pass
// depends on demq_pkg, demq_ctrl and demq_dp
`default_nettype none

module double_ended_message_queue
    import demq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [FUNC_W-1:0]      i_func,
    input  wire logic [PORT_DATA_W-1:0] i_write_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic                        o_ok,
    output logic [PORT_DATA_W-1:0]      o_read_data,
    output logic [CNT_W-1:0]            o_msg_count,
    output logic [CNT_W-1:0]            o_free_space,
    input  wire logic                   i_cfg_we,
    input  wire logic [CNT_W-1:0]       i_cfg_wdata
);

    t_dp_cmd cmd;

    // sequencing and handshakes
    demq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // queue storage and arithmetic
    demq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_func),
        .i_write_data (i_write_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_ok         (o_ok),
        .o_read_data  (o_read_data),
        .o_msg_count  (o_msg_count),
        .o_free_space (o_free_space)
    );

endmodule

`default_nettype wire

// ===== tb/double_ended_message_queue_tb.sv =====
// self-checking testbench for the double-ended message queue
// a scoreboard class predicts each result from the accepted items; tasks drive the ports
// depends on demq_pkg and double_ended_message_queue
`timescale 1ns / 100ps

module double_ended_message_queue_tb
    import demq_pkg::*;
();

    localparam int     QUEUE_DEPTH     = 16;
    localparam int     HALF_PERIOD     = 6;
    localparam int     RESET_CYCLES    = 9;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     SETTLE_CYCLES   = 4;
    localparam int     PHASE_ITEMS     = 150;
    localparam longint RUN_LIMIT_NS    = 64'd12_000_000;

    // one predicted result item
    typedef struct packed {
        logic                   ok;
        logic [PORT_DATA_W-1:0] read_data;
        logic [CNT_W-1:0]       msg_count;
        logic [CNT_W-1:0]       free_space;
    } t_queue_result;

    // ring buffer predictor and store of predicted results
    class msg_queue_scoreboard;
        logic [PORT_DATA_W-1:0] slots [QUEUE_DEPTH];
        int unsigned            back_idx;
        int unsigned            front_idx;
        int unsigned            held;
        int unsigned            cap;
        t_queue_result          pending_results [$];
        int                     errors;
        int                     checked;

        function new();
            foreach (slots[i]) slots[i] = '0;
            errors  = 0;
            checked = 0;
            cap     = QUEUE_DEPTH;
            empty_ring();
        endfunction

        function void empty_ring();
            held      = 0;
            back_idx  = 0;
            front_idx = cap - 1;
        endfunction

        function int unsigned step_up(int unsigned idx);
            return (idx + 1 >= cap) ? 0 : idx + 1;
        endfunction

        function int unsigned step_down(int unsigned idx);
            return (idx == 0) ? cap - 1 : idx - 1;
        endfunction

        // out of range writes clamp to 1..depth, any write empties the queue
        function void set_capacity(logic [CNT_W-1:0] value);
            if (value == 0)
                cap = 1;
            else if (value > QUEUE_DEPTH)
                cap = QUEUE_DEPTH;
            else
                cap = 32'(value);
            empty_ring();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // apply one accepted item and queue its result
        function void note_item(logic [FUNC_W-1:0] func, logic [PORT_DATA_W-1:0] data);
            t_queue_result r;
            logic          full;
            r    = '0;
            full = (held >= cap);
            unique case (func)
                FN_SEND_BACK: begin
                    if (!full) begin
                        slots[back_idx] = data;
                        back_idx        = step_up(back_idx);
                        held++;
                        r.ok = 1'b1;
                    end
                end
                FN_SEND_FRONT: begin
                    if (!full) begin
                        slots[front_idx] = data;
                        front_idx        = step_down(front_idx);
                        held++;
                        r.ok = 1'b1;
                    end
                end
                FN_OVERWRITE: begin
                    // when full the new item lands on the rearmost one
                    slots[front_idx] = data;
                    front_idx        = step_down(front_idx);
                    if (full)
                        back_idx = step_down(back_idx);
                    else
                        held++;
                    r.ok = 1'b1;
                end
                FN_RECEIVE: begin
                    if (held > 0) begin
                        front_idx   = step_up(front_idx);
                        r.read_data = slots[front_idx];
                        held--;
                        r.ok = 1'b1;
                    end
                end
                FN_PEEK: begin
                    if (held > 0) begin
                        r.read_data = slots[step_up(front_idx)];
                        r.ok        = 1'b1;
                    end
                end
                default: ;
            endcase
            r.msg_count  = CNT_W'(held);
            r.free_space = CNT_W'(cap - held);
            pending_results.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic ok, logic [PORT_DATA_W-1:0] read_data,
                                   logic [CNT_W-1:0] msg_count, logic [CNT_W-1:0] free_space);
            t_queue_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result item with none outstanding: ok=%0d read_data=%h count=%0d",
                       ok, read_data, msg_count);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (ok !== want.ok) begin
                errors++;
                $error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
            end
            if (read_data !== want.read_data) begin
                errors++;
                $error("read_data mismatch: expected %h, actual %h", want.read_data, read_data);
            end
            if (msg_count !== want.msg_count) begin
                errors++;
                $error("msg_count mismatch: expected %0d, actual %0d", want.msg_count, msg_count);
            end
            if (free_space !== want.free_space) begin
                errors++;
                $error("free_space mismatch: expected %0d, actual %0d",
                       want.free_space, free_space);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [FUNC_W-1:0]      i_func;
    logic [PORT_DATA_W-1:0] i_write_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_ok;
    logic [PORT_DATA_W-1:0] o_read_data;
    logic [CNT_W-1:0]       o_msg_count;
    logic [CNT_W-1:0]       o_free_space;
    logic                   i_cfg_we;
    logic [CNT_W-1:0]       i_cfg_wdata;

    msg_queue_scoreboard sb;
    bit                  rx_random_stall;
    bit                  hold_off_req;
    int                  items_sent;
    int                  capacity_writes;

    double_ended_message_queue #(
        .DEPTH      (QUEUE_DEPTH),
        .DATA_WIDTH (PORT_DATA_W)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ok         (o_ok),
        .o_read_data  (o_read_data),
        .o_msg_count  (o_msg_count),
        .o_free_space (o_free_space),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // free running clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // gap length: mostly none or short, a few long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(3, 1);
        if (roll < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // offer one item until accepted, then idle for the given gap
    task automatic drive_item(logic [FUNC_W-1:0] func, logic [PORT_DATA_W-1:0] data, int gap);
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(func, data);
        items_sent++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // capacity write while the queue is idle
    task automatic write_capacity(logic [CNT_W-1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_capacity(value);
        capacity_writes++;
    endtask

    // random items that swing the queue between empty and full
    task automatic run_random(int count, bit no_gaps);
        logic [FUNC_W-1:0]      func;
        logic [PORT_DATA_W-1:0] data;
        bit                     fill_bias;
        int                     run_left;
        int                     roll;
        fill_bias = 1'b1;
        run_left  = $urandom_range(3 * sb.cap + 2, 2);
        repeat (count) begin
            if (run_left == 0) begin
                fill_bias = !fill_bias;
                run_left  = $urandom_range(3 * sb.cap + 2, 2);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 3)
                func = FUNC_W'($urandom_range(7, 5));
            else if (($urandom_range(99) < 75) == fill_bias)
                func = FUNC_W'($urandom_range(FN_OVERWRITE, FN_SEND_BACK));
            else
                func = ($urandom_range(3) == 0) ? FN_PEEK : FN_RECEIVE;
            roll = $urandom_range(99);
            if (roll < 8)
                data = '0;
            else if (roll < 16)
                data = '1;
            else
                data = $urandom;
            drive_item(func, data, no_gaps ? 0 : gap_len());
        end
    endtask

    // receiver: checks accepted results and drives the output stall
    initial begin : receiver
        int stall_left;
        int hold_left;
        int roll;
        stall_left  = 0;
        hold_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_ok, o_read_data, o_msg_count, o_free_space);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!rx_random_stall) begin
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                roll = $urandom_range(99);
                if (roll < 65) begin
                    i_out_stall <= 1'b0;
                end else begin
                    stall_left  = (roll < 95) ? $urandom_range(2, 0) : $urandom_range(40, 10);
                    i_out_stall <= 1'b1;
                end
            end
        end
    end

    // main sequence
    initial begin : stimulus
        logic [CNT_W-1:0] phase_caps [12];
        sb              = new();
        rx_random_stall = 1'b1;
        hold_off_req    = 1'b0;
        items_sent      = 0;
        capacity_writes = 0;
        phase_caps      = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd24, 5'd3,
                            5'd0, 5'd9, 5'd16, 5'd2, 5'd13, 5'd31};

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_func       <= FN_SEND_BACK;
        i_write_data <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: failing reads and unknown operations
        drive_item(FN_PEEK, 32'h0, gap_len());
        drive_item(FN_RECEIVE, 32'h0, gap_len());
        drive_item(3'd5, 32'hFFFF_FFFF, gap_len());
        drive_item(3'd6, 32'hFFFF_FFFF, 0);
        drive_item(3'd7, 32'h0, 0);
        // both ends and a non-full overwrite at the default capacity
        drive_item(FN_SEND_BACK, 32'hFFFF_FFFF, 0);
        drive_item(FN_SEND_FRONT, 32'h0, gap_len());
        drive_item(FN_OVERWRITE, 32'hA5A5_5A5A, 0);
        drive_item(FN_PEEK, 32'h0, 0);
        drive_item(FN_RECEIVE, 32'h0, 0);
        drive_item(FN_RECEIVE, 32'h0, gap_len());

        // capacity two: full sends fail, full overwrite drops the rearmost item
        write_capacity(5'd2);
        drive_item(FN_SEND_BACK, 32'h1111_1111, 0);
        drive_item(FN_SEND_FRONT, 32'h2222_2222, 0);
        drive_item(FN_SEND_BACK, 32'h3333_3333, gap_len());
        drive_item(FN_SEND_FRONT, 32'h4444_4444, 0);
        drive_item(FN_OVERWRITE, 32'h5555_5555, 0);
        drive_item(FN_PEEK, 32'h0, 0);
        drive_item(FN_RECEIVE, 32'h0, gap_len());
        drive_item(FN_RECEIVE, 32'h0, 0);
        drive_item(FN_RECEIVE, 32'h0, 0);

        // zero clamps to a single slot
        write_capacity(5'd0);
        drive_item(FN_OVERWRITE, 32'h0123_4567, 0);
        drive_item(FN_OVERWRITE, 32'h89AB_CDEF, 0);
        drive_item(FN_SEND_BACK, 32'hFFFF_0000, gap_len());
        drive_item(3'd7, 32'h0, 0);
        drive_item(FN_RECEIVE, 32'h0, 0);

        // random phases over a spread of capacities, the out of range ones included
        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            rx_random_stall = (p % 4 != 2);
            if (p == 5)
                hold_off_req = 1'b1;
            run_random(PHASE_ITEMS, (p % 4 == 1) || (p == 5));
        end

        drain();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);

        $display("summary: %0d items accepted, %0d results compared, %0d capacity writes",
                 items_sent, sb.checked, capacity_writes);
        $display("covered empty and full queues, overwrite drop, unknown operations, stalls");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== double_ended_message_queue.f =====
+incdir+sv
sv/demq_pkg.sv
sv/demq_ctrl.sv
sv/demq_dp.sv
sv/double_ended_message_queue.sv
tb/double_ended_message_queue_tb.sv
